>>> rtl/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and helpers of the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY      = 128;
  localparam int KEY_WIDTH     = 16;
  localparam int PAYLOAD_WIDTH = 32;

  // slot index, count (holds CAPACITY itself), child index (2*pos+1)
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 1;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]     key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr0;
    logic [IDX_W-1:0] raddr1;
  } ram_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     top_valid;
    logic [KEY_WIDTH-1:0]     top_key;
    logic [PAYLOAD_WIDTH-1:0] top_payload;
    logic [7:0]               entry_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // true when key kb should stand above key ka (strict)
  function automatic logic better_f(input logic mode,
                                    input logic [KEY_WIDTH-1:0] ka,
                                    input logic [KEY_WIDTH-1:0] kb);
    logic r;
    r = mode ? (ka > kb) : (ka < kb);
    return r;
  endfunction

endpackage

>>> rtl/bhpq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_in_if
// Request channel of the priority queue: push or pop with entry fields.
// ----------------------------------------------------------------------------
interface bhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [bhpq_pkg::KEY_WIDTH-1:0]     entry_key;
  logic [bhpq_pkg::PAYLOAD_WIDTH-1:0] entry_payload;

  modport source (output valid, output opcode, output entry_key, output entry_payload,
                  input ready);
  modport sink   (input valid, input opcode, input entry_key, input entry_payload,
                  output ready);
endinterface

>>> rtl/bhpq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_out_if
// Result channel of the priority queue: status, top entry and count.
// ----------------------------------------------------------------------------
interface bhpq_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic                               top_valid;
  logic [bhpq_pkg::KEY_WIDTH-1:0]     top_key;
  logic [bhpq_pkg::PAYLOAD_WIDTH-1:0] top_payload;
  logic [7:0]                         entry_count;

  modport source (output valid, output status, output top_valid, output top_key,
                  output top_payload, output entry_count, input ready);
  modport sink   (input valid, input status, input top_valid, input top_key,
                  input top_payload, input entry_count, output ready);
endinterface

>>> rtl/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Heap-ordered priority queue of key/payload entries with push and pop.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per handshake, opcode push (key, payload) or pop.
//   out_ch : one result per request: status, top entry after the request
//            with a valid flag, and the entry count.
//   cfg_we / cfg_wdata : order mode, 0 = largest key on top, 1 = smallest.
//            Write only while no request is in flight.
// Timing:
//   Each heap level takes a memory read, then a compare and write-back. A
//   push sifts up over the levels that it climbs; a pop first reads the
//   last entry into the hole at the root, then sifts down. The result then
//   waits in the sequencer's finish state until the output register takes
//   it. A rejected request, or a pop that empties the queue, goes straight
//   to the finish state. Between requests the sequencer passes through its
//   finish and idle states after the sift. A new request is taken as soon
//   as the sequencer is idle, even while the previous result waits in the
//   output register; a stalled receiver holds the sequencer only once its
//   next result is ready.
// Reset: rst_n (synchronous) empties the queue and selects largest-first.
//   The memory needs no clearing; slots are read only after being written.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  bhpq_in_if.sink    in_ch,
  bhpq_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic                 order_mode_r;
  logic                 res_valid;
  logic                 res_take;
  bhpq_pkg::result_t    res;
  bhpq_pkg::ram_req_t   ram_req;
  bhpq_pkg::entry_t     ram_rd0;
  bhpq_pkg::entry_t     ram_rd1;
  logic                 out_valid_r;
  bhpq_pkg::result_t    out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
    end else if (cfg_we) begin
      order_mode_r <= cfg_wdata;
    end
  end

  bhpq_heap_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .rd0 (ram_rd0),
    .rd1 (ram_rd1)
  );

  bhpq_sift_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .order_mode  (order_mode_r),
    .req_valid   (in_ch.valid),
    .req_ready   (in_ch.ready),
    .req_opcode  (in_ch.opcode),
    .req_key     (in_ch.entry_key),
    .req_payload (in_ch.entry_payload),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd0     (ram_rd0),
    .ram_rd1     (ram_rd1)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.top_valid   = out_res_r.top_valid;
  assign out_ch.top_key     = out_res_r.top_key;
  assign out_ch.top_payload = out_res_r.top_payload;
  assign out_ch.entry_count = out_res_r.entry_count;

endmodule

>>> rtl/bhpq_heap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_heap_ram
// Heap storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bhpq_heap_ram (
  input  logic               clk,
  input  bhpq_pkg::ram_req_t req,
  output bhpq_pkg::entry_t   rd0,
  output bhpq_pkg::entry_t   rd1
);

  bhpq_pkg::entry_t mem [bhpq_pkg::CAPACITY];
  bhpq_pkg::entry_t rd0_r;
  bhpq_pkg::entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd0_r <= mem[req.raddr0];
    rd1_r <= mem[req.raddr1];
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

>>> rtl/bhpq_sift_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_sift_ctrl
// Sequencer for push (sift up) and pop (sift down) over the heap memory.
// ----------------------------------------------------------------------------
module bhpq_sift_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               order_mode,
  // request side
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic                               req_opcode,
  input  logic [bhpq_pkg::KEY_WIDTH-1:0]     req_key,
  input  logic [bhpq_pkg::PAYLOAD_WIDTH-1:0] req_payload,
  // result side
  output logic                               res_valid,
  input  logic                               res_take,
  output bhpq_pkg::result_t                  res,
  // memory
  output bhpq_pkg::ram_req_t                 ram_req,
  input  bhpq_pkg::entry_t                   ram_rd0,
  input  bhpq_pkg::entry_t                   ram_rd1
);

  localparam int IDX_W = bhpq_pkg::IDX_W;
  localparam int CNT_W = bhpq_pkg::CNT_W;
  localparam int CH_W  = bhpq_pkg::CH_W;

  bhpq_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  bhpq_pkg::entry_t ent_r, ent_nxt;
  bhpq_pkg::entry_t top_r;

  logic [IDX_W-1:0] parent;
  logic [CH_W-1:0]  child0;
  logic [CH_W-1:0]  child1;
  logic [CH_W-1:0]  count_ext;
  logic [CNT_W-1:0] count_dec;
  logic             has_child;
  logic             has_two;
  logic             pick_right;
  bhpq_pkg::entry_t child_ent;
  logic [IDX_W-1:0] child_idx;

  assign parent    = IDX_W'(pos_r - IDX_W'(1)) >> 1;
  assign child0    = {pos_r, 1'b1};
  assign child1    = CH_W'(child0 + CH_W'(1));
  assign count_ext = CH_W'(count_r);
  assign count_dec = CNT_W'(count_r - CNT_W'(1));
  assign has_child = child0 < count_ext;
  // child1 can only wrap when child0 is already past the end
  assign has_two   = child1 < count_ext;
  assign pick_right = has_two && bhpq_pkg::better_f(order_mode, ram_rd0.key, ram_rd1.key);
  assign child_ent = pick_right ? ram_rd1 : ram_rd0;
  assign child_idx = pick_right ? child1[IDX_W-1:0] : child0[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bhpq_pkg::S_IDLE;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    ent_r    <= ent_nxt;
    status_r <= status_nxt;
    // mirror of slot 0 for the result
    if (ram_req.we && ram_req.waddr == '0) begin
      top_r <= ram_req.wdata;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ent_nxt    = ent_r;
    ram_req    = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      bhpq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          status_nxt = bhpq_pkg::ST_DONE;
          if (req_opcode == bhpq_pkg::OP_PUSH) begin
            if (count_r == CNT_W'(bhpq_pkg::CAPACITY)) begin
              status_nxt = bhpq_pkg::ST_FULL;
              state_nxt  = bhpq_pkg::S_FINISH;
            end else begin
              ent_nxt.key     = req_key;
              ent_nxt.payload = req_payload;
              pos_nxt         = count_r[IDX_W-1:0];
              count_nxt       = CNT_W'(count_r + CNT_W'(1));
              state_nxt       = bhpq_pkg::S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bhpq_pkg::ST_EMPTY;
              state_nxt  = bhpq_pkg::S_FINISH;
            end else begin
              count_nxt = count_dec;
              if (count_dec == '0) begin
                state_nxt = bhpq_pkg::S_FINISH;
              end else begin
                ram_req.raddr0 = count_dec[IDX_W-1:0];  // last entry
                state_nxt      = bhpq_pkg::S_DN_LAST;
              end
            end
          end
        end
      end

      bhpq_pkg::S_UP_RD: begin
        if (pos_r == '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = ent_r;
          state_nxt     = bhpq_pkg::S_FINISH;
        end else begin
          ram_req.raddr0 = parent;
          state_nxt      = bhpq_pkg::S_UP_CMP;
        end
      end

      bhpq_pkg::S_UP_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (bhpq_pkg::better_f(order_mode, ram_rd0.key, ent_r.key)) begin
          // parent moves down into the hole
          ram_req.wdata = ram_rd0;
          pos_nxt       = parent;
          state_nxt     = bhpq_pkg::S_UP_RD;
        end else begin
          ram_req.wdata = ent_r;
          state_nxt     = bhpq_pkg::S_FINISH;
        end
      end

      bhpq_pkg::S_DN_LAST: begin
        ent_nxt   = ram_rd0;
        pos_nxt   = '0;
        state_nxt = bhpq_pkg::S_DN_RD;
      end

      bhpq_pkg::S_DN_RD: begin
        if (!has_child) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = ent_r;
          state_nxt     = bhpq_pkg::S_FINISH;
        end else begin
          ram_req.raddr0 = child0[IDX_W-1:0];
          ram_req.raddr1 = child1[IDX_W-1:0];
          state_nxt      = bhpq_pkg::S_DN_CMP;
        end
      end

      bhpq_pkg::S_DN_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (bhpq_pkg::better_f(order_mode, ent_r.key, child_ent.key)) begin
          ram_req.wdata = child_ent;
          pos_nxt       = child_idx;
          state_nxt     = bhpq_pkg::S_DN_RD;
        end else begin
          ram_req.wdata = ent_r;
          state_nxt     = bhpq_pkg::S_FINISH;
        end
      end

      bhpq_pkg::S_FINISH: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.top_valid   = count_r != '0;
    res.top_key     = (count_r != '0) ? top_r.key : '0;
    res.top_payload = (count_r != '0) ? top_r.payload : '0;
    res.entry_count = 8'(count_r);
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary heap priority queue. A scoreboard heap
// in the bench tracks every accepted push and pop and predicts the status,
// top entry and count of each result; directed cases cover the empty and
// full corners, tied keys and a mode flip with entries held, then random
// push/pop traffic runs in both orders with bursty requests and stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bhpq_in_if  in_ch ();
  bhpq_out_if out_ch ();

  binary_heap_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scoreboard heap
  bhpq_pkg::entry_t  sb_slot [bhpq_pkg::CAPACITY];
  int                sb_len;
  logic              sb_min_first;
  bhpq_pkg::result_t expected_results [$];

  int fail_count;
  int idle_cycles;

  // request pacing
  bit sender_gaps;
  int burst_left;

  // result-side stall control
  bit rx_patterned;
  int hold_req;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // true when entry hi should sit above entry lo under the current order
  function automatic bit outranks(input bhpq_pkg::entry_t lo, input bhpq_pkg::entry_t hi);
    return sb_min_first ? (lo.key > hi.key) : (lo.key < hi.key);
  endfunction

  function automatic bhpq_pkg::result_t apply_request(
      input logic op,
      input logic [bhpq_pkg::KEY_WIDTH-1:0] key,
      input logic [bhpq_pkg::PAYLOAD_WIDTH-1:0] payload);
    bhpq_pkg::result_t r;
    bhpq_pkg::entry_t  t;
    int                pos;
    int                nxt;
    bit                settled;
    r.status = bhpq_pkg::ST_DONE;
    if (op == bhpq_pkg::OP_PUSH) begin
      if (sb_len >= bhpq_pkg::CAPACITY) begin
        r.status = bhpq_pkg::ST_FULL;
      end else begin
        sb_slot[sb_len].key     = key;
        sb_slot[sb_len].payload = payload;
        pos = sb_len;
        sb_len++;
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          nxt = (pos - 1) / 2;
          if (outranks(sb_slot[nxt], sb_slot[pos])) begin
            t = sb_slot[nxt];
            sb_slot[nxt] = sb_slot[pos];
            sb_slot[pos] = t;
            pos = nxt;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else begin
      if (sb_len == 0) begin
        r.status = bhpq_pkg::ST_EMPTY;
      end else begin
        sb_len--;
        if (sb_len > 0) begin
          sb_slot[0] = sb_slot[sb_len];
          pos = 0;
          settled = 1'b0;
          while (2 * pos + 1 < sb_len && !settled) begin
            nxt = 2 * pos + 1;
            if (nxt + 1 < sb_len && outranks(sb_slot[nxt], sb_slot[nxt + 1]))
              nxt++;
            if (outranks(sb_slot[pos], sb_slot[nxt])) begin
              t = sb_slot[nxt];
              sb_slot[nxt] = sb_slot[pos];
              sb_slot[pos] = t;
              pos = nxt;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end
    r.top_valid   = (sb_len > 0);
    r.top_key     = (sb_len > 0) ? sb_slot[0].key : '0;
    r.top_payload = (sb_len > 0) ? sb_slot[0].payload : '0;
    r.entry_count = 8'(sb_len);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken, unless a pacing gap with valid low follows
  task automatic send_req(input logic op, input logic [bhpq_pkg::KEY_WIDTH-1:0] key,
                          input logic [bhpq_pkg::PAYLOAD_WIDTH-1:0] payload);
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.entry_key     <= key;
    in_ch.entry_payload <= payload;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(apply_request(op, key, payload));
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
        burst_left = $urandom_range(24, 0);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order_mode(input logic min_first);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= min_first;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb_min_first = min_first;
  endtask

  function automatic logic [bhpq_pkg::KEY_WIDTH-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return bhpq_pkg::KEY_WIDTH'($urandom());
    if (sel < 90) return bhpq_pkg::KEY_WIDTH'($urandom_range(7));
    return $urandom_range(1) ? '1 : '0;
  endfunction

  task automatic test_directed();
    set_order_mode(1'b0);
    send_req(bhpq_pkg::OP_POP, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(bhpq_pkg::OP_PUSH, 16'h1234, 32'h0000_00A5);
    send_req(bhpq_pkg::OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(bhpq_pkg::OP_PUSH, 16'h0000, 32'h0000_0000);
    // tie with the root: must not displace it
    send_req(bhpq_pkg::OP_PUSH, 16'hFFFF, 32'h0000_0001);
    send_req(bhpq_pkg::OP_PUSH, 16'h8000, 32'hAAAA_AAAA);
    send_req(bhpq_pkg::OP_PUSH, 16'h0000, 32'h5555_5555);
    repeat (6) send_req(bhpq_pkg::OP_POP, 16'h0000, 32'h0000_0000);
    send_req(bhpq_pkg::OP_POP, 16'h5A5A, 32'h1234_5678);
    // ties deeper in the heap
    send_req(bhpq_pkg::OP_PUSH, 16'h0007, 32'h0000_0010);
    send_req(bhpq_pkg::OP_PUSH, 16'h0007, 32'h0000_0011);
    send_req(bhpq_pkg::OP_PUSH, 16'h0007, 32'h0000_0012);
    send_req(bhpq_pkg::OP_PUSH, 16'h0003, 32'h0000_0013);
    send_req(bhpq_pkg::OP_PUSH, 16'h0009, 32'h0000_0014);
    send_req(bhpq_pkg::OP_POP, 16'hFFFF, 32'h0);
    send_req(bhpq_pkg::OP_POP, 16'hFFFF, 32'h0);
    wait_results_drained();
  endtask

  // entries stay in place across the flip; later sifts use the new order
  task automatic test_mode_flip_held();
    set_order_mode(1'b1);
    send_req(bhpq_pkg::OP_PUSH, 16'h0005, 32'hC0DE_0001);
    send_req(bhpq_pkg::OP_PUSH, 16'hFFFF, 32'hC0DE_0002);
    send_req(bhpq_pkg::OP_PUSH, 16'h0000, 32'hC0DE_0003);
    while (sb_len > 0) send_req(bhpq_pkg::OP_POP, 16'h0, 32'h0);
    send_req(bhpq_pkg::OP_POP, 16'h0, 32'h0);
    wait_results_drained();
  endtask

  // receiver holds off while the sender keeps offering, then fill to the
  // rejection point and drain past empty
  task automatic test_fill_and_drain();
    sender_gaps = 1'b0;
    hold_req    = HOLD_CYCLES;
    while (sb_len < bhpq_pkg::CAPACITY) send_req(bhpq_pkg::OP_PUSH, pick_key(), $urandom());
    repeat (3) send_req(bhpq_pkg::OP_PUSH, pick_key(), $urandom());
    sender_gaps = 1'b1;
    while (sb_len > 0) send_req(bhpq_pkg::OP_POP, pick_key(), $urandom());
    repeat (2) send_req(bhpq_pkg::OP_POP, pick_key(), $urandom());
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input logic min_first,
                                     input bit use_gaps, input bit use_stalls);
    int   push_pct;
    logic op;
    set_order_mode(min_first);
    sender_gaps  = use_gaps;
    rx_patterned = use_stalls;
    push_pct     = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) push_pct = $urandom_range(80, 25);
      op = ($urandom_range(99) < push_pct) ? bhpq_pkg::OP_PUSH : bhpq_pkg::OP_POP;
      send_req(op, pick_key(), $urandom());
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= bhpq_pkg::OP_PUSH;
    in_ch.entry_key     <= '0;
    in_ch.entry_payload <= '0;
    sb_len       = 0;
    sb_min_first = 1'b0;
    fail_count   = 0;
    sender_gaps  = 1'b1;
    burst_left   = 0;
    rx_patterned = 1'b1;
    hold_req     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_mode_flip_held();
    test_fill_and_drain();
    test_random_traffic(600, 1'b0, 1'b1, 1'b1);
    test_random_traffic(600, 1'b1, 1'b1, 1'b1);
    test_random_traffic(250, 1'b0, 1'b0, 1'b0);
    test_random_traffic(200, 1'b1, 1'b1, 1'b1);

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result-side ready: long hold on request, else alternating runs, or always ready when patterning is off
  initial begin
    int  hold_left;
    int  run_left;
    bit  run_ready;
    hold_left = 0;
    run_left  = 0;
    run_ready = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!rx_patterned) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          run_left  = run_ready ? $urandom_range(12, 1) : $urandom_range(8, 1);
        end
        run_left--;
        out_ch.ready <= run_ready;
      end
    end
  end

  always @(posedge clk) begin
    bhpq_pkg::result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no request pending");
        fail_count++;
      end else begin
        due = expected_results.pop_front();
        if (out_ch.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.top_valid !== due.top_valid) begin
          $error("top_valid: expected %0d, got %0d", due.top_valid, out_ch.top_valid);
          fail_count++;
        end
        if (out_ch.top_key !== due.top_key) begin
          $error("top_key: expected %0h, got %0h", due.top_key, out_ch.top_key);
          fail_count++;
        end
        if (out_ch.top_payload !== due.top_payload) begin
          $error("top_payload: expected %0h, got %0h", due.top_payload,
                 out_ch.top_payload);
          fail_count++;
        end
        if (out_ch.entry_count !== due.entry_count) begin
          $error("entry_count: expected %0d, got %0d", due.entry_count,
                 out_ch.entry_count);
          fail_count++;
        end
      end
    end
  end

  // no progress on either channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
